// ===== rtl/utf8_validating_decoder_top_assert.svh =====
// assertion macros for the utf-8 decoder, sampled on clk, disabled in reset
`ifndef UTF8_VALIDATING_DECODER_TOP_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent on one edge implies consequent on the same edge
`define UVD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// expression must hold on every edge
`define UVD_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant check failed");

`else

`define UVD_ASSERT_IMPLY(lbl, ante, cons)
`define UVD_ASSERT_ALWAYS(lbl, expr)

`endif

`endif

// ===== rtl/utf8vd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package utf8vd_pkg;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD  = 2'd1;
    localparam logic [1:0] ST_BAD_CONT  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // one input word: a raw byte and its end-of-buffer mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_word_t;

    // one result word
    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  status;
        logic [15:0] byte_offset;
        logic [2:0]  seq_length;
        logic        end_of_buffer;
    } out_word_t;

    // step logic to result register
    typedef struct packed {
        logic      emit;
        out_word_t word;
    } step_res_t;

endpackage

`default_nettype wire

// ===== rtl/utf8vd_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module utf8vd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                raw_valid,
    output logic                raw_stall,
    input  utf8vd_pkg::in_word_t raw,
    input  logic                advance,
    output logic                held_valid,
    output utf8vd_pkg::in_word_t held
);
    import utf8vd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     load;

    // hold off the source only while a word sits here and cannot move on
    assign raw_stall = valid_reg && !advance;
    assign load      = raw_valid && !raw_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= raw;
        end
    end

    assign held_valid = valid_reg;
    assign held       = word_reg;

endmodule

`default_nettype wire

// ===== rtl/utf8vd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module utf8vd_core #(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  utf8vd_pkg::in_word_t item,
    output utf8vd_pkg::step_res_t res
);
    import utf8vd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLLECT,
        PH_PENDING,
        PH_SKIP
    } phase_t;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    // continuation bytes owed after a lead
    function automatic logic [1:0] cont_count(input logic [7:0] lead);
        logic [1:0] n;
        begin
            if (lead >= 8'hF0)
            begin
                n = 2'd3;
            end
            else if (lead >= 8'hE0)
            begin
                n = 2'd2;
            end
            else
            begin
                n = 2'd1;
            end
            return n;
        end
    endfunction

    // narrowed second-byte ranges after e0, ed, f0 and f4
    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        begin
            unique case (lead)
                8'hE0: ok = (b >= 8'hA0) && (b <= 8'hBF);
                8'hED: ok = (b >= 8'h80) && (b <= 8'h9F);
                8'hF0: ok = (b >= 8'h90) && (b <= 8'hBF);
                8'hF4: ok = (b >= 8'h80) && (b <= 8'h8F);
                default: ok = (b[7:6] == 2'b10);
            endcase
            return ok;
        end
    endfunction

    phase_t                 phase_reg, phase_next;
    logic [1:0]             needed_reg, needed_next;
    logic [1:0]             seen_reg, seen_next;
    logic [7:0]             lead_reg, lead_next;
    logic [20:0]            acc_reg, acc_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] lead_off_reg, lead_off_next;
    logic [OFFSET_BITS-1:0] pend_off_reg, pend_off_next;

    logic [7:0]             b;
    logic                   eob;
    logic                   cont_ok;
    logic                   last;
    logic [2:0]             so_far;
    logic [1:0]             nc_in;
    logic [1:0]             pend_needed;
    logic [2:0]             trunc_len;
    logic [20:0]            acc_shift;
    logic [20:0]            acc_init;

    logic                   emit;
    logic [20:0]            cp;
    logic [1:0]             st;
    logic [OFFSET_BITS-1:0] off_sel;
    logic [OFFSET_BITS+15:0] off_wide;
    logic [2:0]             len;

    assign b   = item.data_byte;
    assign eob = item.buffer_end;

    // per-byte checks and arithmetic
    assign cont_ok     = (seen_reg == 2'd0) ? second_ok(lead_reg, b) : (b[7:6] == 2'b10);
    assign last        = (needed_reg <= 2'd1);
    assign so_far      = {1'b0, seen_reg} + 3'd2;
    assign nc_in       = cont_count(b);
    assign pend_needed = (needed_reg != 2'd0) ? (needed_reg - 2'd1) : needed_reg;
    assign trunc_len   = {1'b0, cont_count(lead_reg)} + 3'd1 - {1'b0, pend_needed};
    assign acc_shift   = {acc_reg[14:0], b[5:0]};

    // payload bits of the lead byte
    always_comb
    begin
        unique case (nc_in)
            2'd1:    acc_init = {16'b0, b[4:0]};
            2'd2:    acc_init = {17'b0, b[3:0]};
            default: acc_init = {18'b0, b[2:0]};
        endcase
    end

    // next state and result for the word at the head
    always_comb
    begin
        phase_next    = phase_reg;
        needed_next   = needed_reg;
        seen_next     = seen_reg;
        lead_next     = lead_reg;
        acc_next      = acc_reg;
        pos_next      = pos_reg;
        lead_off_next = lead_off_reg;
        pend_off_next = pend_off_reg;
        emit          = 1'b0;
        cp            = '0;
        st            = ST_OK;
        off_sel       = pos_reg;
        len           = 3'd1;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!b[7])
                begin
                    emit = 1'b1;
                    cp   = {13'b0, b};
                end
                else if ((b < 8'hC2) || (b > 8'hF4))
                begin
                    emit = 1'b1;
                    st   = ST_BAD_LEAD;
                    if (!eob)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                else if (eob)
                begin
                    emit = 1'b1;
                    st   = ST_TRUNCATED;
                end
                else
                begin
                    lead_next     = b;
                    lead_off_next = pos_reg;
                    needed_next   = nc_in;
                    seen_next     = 2'd0;
                    acc_next      = acc_init;
                    phase_next    = PH_COLLECT;
                end
            end
            PH_COLLECT:
            begin
                if (cont_ok)
                begin
                    acc_next = acc_shift;
                    if (last)
                    begin
                        emit       = 1'b1;
                        cp         = acc_shift;
                        off_sel    = lead_off_reg;
                        len        = so_far;
                        phase_next = PH_IDLE;
                    end
                    else if (eob)
                    begin
                        emit       = 1'b1;
                        st         = ST_TRUNCATED;
                        off_sel    = lead_off_reg;
                        len        = so_far;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        seen_next   = seen_reg + 2'd1;
                        needed_next = needed_reg - 2'd1;
                    end
                end
                else if (last)
                begin
                    emit       = 1'b1;
                    st         = ST_BAD_CONT;
                    len        = so_far;
                    phase_next = eob ? PH_IDLE : PH_SKIP;
                end
                else if (eob)
                begin
                    emit       = 1'b1;
                    st         = ST_TRUNCATED;
                    off_sel    = lead_off_reg;
                    len        = so_far;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    pend_off_next = pos_reg;
                    seen_next     = seen_reg + 2'd1;
                    needed_next   = needed_reg - 2'd1;
                    phase_next    = PH_PENDING;
                end
            end
            PH_PENDING:
            begin
                needed_next = pend_needed;
                if (pend_needed == 2'd0)
                begin
                    emit       = 1'b1;
                    st         = ST_BAD_CONT;
                    off_sel    = pend_off_reg;
                    len        = {1'b0, seen_reg} + 3'd1;
                    phase_next = eob ? PH_IDLE : PH_SKIP;
                end
                else if (eob)
                begin
                    emit       = 1'b1;
                    st         = ST_TRUNCATED;
                    off_sel    = lead_off_reg;
                    len        = trunc_len;
                    phase_next = PH_IDLE;
                end
            end
            PH_SKIP:
            begin
                if (eob)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // offset counter: restart per buffer, saturate at the top
        if (eob)
        begin
            pos_next = '0;
            if (phase_next == PH_IDLE)
            begin
                needed_next = 2'd0;
                seen_next   = 2'd0;
            end
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // result word, offset cut or widened to 16 bits
    assign off_wide = {16'b0, off_sel};

    always_comb
    begin
        res.emit               = emit && advance;
        res.word.code_point    = cp;
        res.word.status        = st;
        res.word.byte_offset   = off_wide[15:0];
        res.word.seq_length    = len;
        res.word.end_of_buffer = eob;
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            needed_reg   <= 2'd0;
            seen_reg     <= 2'd0;
            lead_reg     <= 8'd0;
            acc_reg      <= 21'd0;
            pos_reg      <= '0;
            lead_off_reg <= '0;
            pend_off_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            needed_reg   <= needed_next;
            seen_reg     <= seen_next;
            lead_reg     <= lead_next;
            acc_reg      <= acc_next;
            pos_reg      <= pos_next;
            lead_off_reg <= lead_off_next;
            pend_off_reg <= pend_off_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utf8vd_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module utf8vd_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  utf8vd_pkg::step_res_t res,
    input  logic                  dec_stall,
    output logic                  dec_valid,
    output utf8vd_pkg::out_word_t dec,
    output logic                  out_ready
);
    import utf8vd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    // free when empty or when the held word leaves this edge
    assign out_ready = !valid_reg || !dec_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = res.emit;
        end
        else if (!dec_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            word_reg <= res.word;
        end
    end

    assign dec_valid = valid_reg;
    assign dec       = word_reg;

endmodule

`default_nettype wire

// ===== rtl/utf8_validating_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 validating decoder. Takes one byte word per cycle on the raw channel
// while raw_stall is low, and gives at most one result word on the dec
// channel per byte: a code point for each complete well-formed character, or
// one error word (bad lead, bad continuation, truncated) for the first fault
// in a buffer, after which bytes are dropped up to buffer_end. Each byte
// passes an input register, one stage of compare and shift logic that
// updates the decoder state, and a result register that takes its outcome
// when the byte leaves the input register; the single state update per byte
// sets the byte rate.
// raw_stall rises only while the input register is full and the result
// register holds a word that dec_stall keeps back. Offsets count within a
// buffer, saturate at 2^OFFSET_BITS - 1, and byte_offset carries the low
// 16 bits.
module utf8_validating_decoder_top #(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  raw_valid,
    output logic                  raw_stall,
    input  utf8vd_pkg::in_word_t  raw,
    output logic                  dec_valid,
    input  logic                  dec_stall,
    output utf8vd_pkg::out_word_t dec
);
    import utf8vd_pkg::*;

`include "utf8_validating_decoder_top_assert.svh"

    logic      held_valid;
    in_word_t  held;
    logic      out_ready;
    logic      advance;
    step_res_t res;
    logic      ok_word;
    logic      bad_lead_word;
    logic      cp_surrogate;

    // a held byte moves when the result register can take its outcome
    assign advance = held_valid && out_ready;

    utf8vd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_valid  (raw_valid),
        .raw_stall  (raw_stall),
        .raw        (raw),
        .advance    (advance),
        .held_valid (held_valid),
        .held       (held)
    );

    utf8vd_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held),
        .res     (res)
    );

    utf8vd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res       (res),
        .dec_stall (dec_stall),
        .dec_valid (dec_valid),
        .dec       (dec),
        .out_ready (out_ready)
    );

    // checks
    assign ok_word       = dec_valid && (dec.status == ST_OK);
    assign bad_lead_word = dec_valid && (dec.status == ST_BAD_LEAD);
    assign cp_surrogate  = (dec.code_point >= 21'h00D800) && (dec.code_point <= 21'h00DFFF);

    `UVD_ASSERT_IMPLY(a_ok_scalar, ok_word, (dec.code_point <= 21'h10FFFF) && !cp_surrogate)
    `UVD_ASSERT_IMPLY(a_err_zero_cp, dec_valid && (dec.status != ST_OK), dec.code_point == 21'd0)
    `UVD_ASSERT_IMPLY(a_bad_lead_len, bad_lead_word, dec.seq_length == 3'd1)
    `UVD_ASSERT_ALWAYS(a_stall_cause, !raw_stall || (dec_valid && dec_stall))

endmodule

`default_nettype wire
